@@ design/lcgu_pkg.sv @@
`default_nettype none

package lcgu_pkg;

   // Lehmer generator constants
   localparam logic [14:0] LCG_MULT  = 15'd16807;
   localparam logic [31:0] LCG_MOD   = 32'h7FFF_FFFF;
   localparam logic [63:0] HALF_LSB  = 64'h0000_0000_4000_0000;

   localparam int QUEUE_DEPTH_DEF = 2;

   typedef enum logic [1:0] {
      OP_DRAW,
      OP_LOAD,
      OP_REJECT
   } lcgu_kind_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] bound_a;
      logic signed [31:0] bound_b;
      logic        [30:0] seed_value;
   } lcgu_req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic        [30:0] seed_out;
      logic               status;
   } lcgu_rsp_type;

   // classified command word passed from front to back
   typedef struct packed {
      lcgu_kind_type      kind;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic        [32:0] span;
      logic        [30:0] seed;
   } lcgu_cmd_type;

endpackage

`default_nettype wire

@@ design/lcgu_front.sv @@
`default_nettype none

module lcgu_front (
   input  lcgu_pkg::lcgu_req_type req_word,
   output lcgu_pkg::lcgu_cmd_type cmd_word
);
   import lcgu_pkg::*;

   logic a_below_b;
   logic seed_bad;
   logic signed [31:0] lo;
   logic signed [31:0] hi;
   logic [32:0] diff;

   // order the bounds and size the interval
   assign a_below_b = req_word.bound_a < req_word.bound_b;
   assign lo        = a_below_b ? req_word.bound_a : req_word.bound_b;
   assign hi        = a_below_b ? req_word.bound_b : req_word.bound_a;
   assign diff      = {hi[31], hi} - {lo[31], lo};

   // zero and the modulus itself would stall the generator
   assign seed_bad = (req_word.seed_value == '0) || (req_word.seed_value == '1);

   always_comb begin
      cmd_word.lo   = lo;
      cmd_word.hi   = hi;
      cmd_word.span = diff + 33'd1;
      cmd_word.seed = req_word.seed_value;
      if (!req_word.func) begin
         cmd_word.kind = OP_DRAW;
      end else if (seed_bad) begin
         cmd_word.kind = OP_REJECT;
      end else begin
         cmd_word.kind = OP_LOAD;
      end
   end

endmodule

`default_nettype wire

@@ design/lcgu_queue.sv @@
`default_nettype none

module lcgu_queue #(
   parameter int DEPTH = lcgu_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   output logic                   push_ready,
   input  lcgu_pkg::lcgu_cmd_type push_word,
   output logic                   pop_valid,
   input  wire                    pop_ready,
   output lcgu_pkg::lcgu_cmd_type pop_word
);
   import lcgu_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcgu_cmd_type     slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff;
   logic [IDX_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count exceeds depth");

   assert property (@(posedge clock) disable iff (reset)
      push_fire && !pop_fire |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset)
      pop_fire && !push_fire |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count missed a pop");

endmodule

`default_nettype wire

@@ design/lcgu_back.sv @@
`default_nettype none

module lcgu_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    cmd_valid,
   output logic                   cmd_ready,
   input  lcgu_pkg::lcgu_cmd_type cmd_word,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output lcgu_pkg::lcgu_rsp_type rsp_word
);
   import lcgu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FOLD,
      S_SPAN,
      S_SUM,
      S_ROUND,
      S_CLAMP,
      S_OUT
   } state_type;

   state_type          state_ff;
   lcgu_cmd_type       cur_ff;
   logic [30:0]        seed_ff;
   logic [45:0]        prod_ff;
   logic [63:0]        term_ff;
   logic [63:0]        acc_ff;
   logic               neg_ff;
   logic [32:0]        mag_ff;
   logic signed [31:0] res_value_ff;
   logic               res_status_ff;
   logic               rsp_valid_ff;
   lcgu_rsp_type       rsp_word_ff;

   logic [31:0]        fold_sum;
   logic [30:0]        seed_in;
   logic [63:0]        lo_shifted;
   logic [63:0]        acc_in;
   logic [63:0]        mag_abs;
   logic [63:0]        mag_rnd;
   logic signed [33:0] rounded;
   logic signed [33:0] lo_ext;
   logic signed [33:0] hi_ext;
   logic signed [31:0] clamp_in;

   assign cmd_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // reduce mod 2^31-1: high part folds back onto the low part
   assign fold_sum = {17'd0, prod_ff[45:31]} + {1'b0, prod_ff[30:0]};
   assign seed_in  = (fold_sum >= LCG_MOD) ? 31'(fold_sum - LCG_MOD) : fold_sum[30:0];

   // lo * 2^31 + seed * span - 1/2, all in 31 fraction bits
   assign lo_shifted = {cur_ff.lo[31], cur_ff.lo, 31'd0};
   assign acc_in     = lo_shifted + term_ff - HALF_LSB;

   // round half away from zero on the magnitude
   assign mag_abs = acc_ff[63] ? (~acc_ff + 64'd1) : acc_ff;
   assign mag_rnd = mag_abs + HALF_LSB;

   assign rounded  = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
   assign lo_ext   = 34'(cur_ff.lo);
   assign hi_ext   = 34'(cur_ff.hi);
   assign clamp_in = (rounded < lo_ext) ? cur_ff.lo :
                     (rounded > hi_ext) ? cur_ff.hi : rounded[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= 31'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // outside S_OUT a taken word simply leaves the output register
         if (rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cur_ff   <= cmd_word;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_value_ff  <= '0;
               res_status_ff <= 1'b0;
               case (cur_ff.kind)
                  OP_DRAW: begin
                     prod_ff  <= seed_ff * LCG_MULT;
                     state_ff <= S_FOLD;
                  end
                  OP_LOAD: begin
                     seed_ff  <= cur_ff.seed;
                     state_ff <= S_OUT;
                  end
                  default: begin
                     res_status_ff <= 1'b1;
                     state_ff      <= S_OUT;
                  end
               endcase
            end
            S_FOLD: begin
               seed_ff  <= seed_in;
               state_ff <= S_SPAN;
            end
            S_SPAN: begin
               term_ff  <= seed_ff * cur_ff.span;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               acc_ff   <= acc_in;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               neg_ff   <= acc_ff[63];
               mag_ff   <= mag_rnd[63:31];
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               res_value_ff <= clamp_in;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_word_ff.value    <= res_value_ff;
                  rsp_word_ff.seed_out <= seed_ff;
                  rsp_word_ff.status   <= res_status_ff;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      seed_ff != '0 && seed_ff != '1)
      else $error("generator seed left the valid range");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLAMP |=> res_value_ff >= cur_ff.lo && res_value_ff <= cur_ff.hi)
      else $error("drawn value outside its bounds");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_valid_ff && !rsp_ready |=> state_ff == S_OUT)
      else $error("result dropped while output stalled");

endmodule

`default_nettype wire

@@ design/lcg_uniform_int_range_unit.sv @@
// A draw word passes the back-end states EXEC, FOLD, SPAN, SUM, ROUND, CLAMP and OUT
// before it shows on rsp, a load word only EXEC and OUT, given an idle back end and
// a free output register. The back-end sequencer carries one word at a time through
// the seed multiply, fold and range map, and takes no new word until the last has left.
// The front accepts up to QUEUE_DEPTH words ahead while the back end is busy.
// Reset: synchronous, active high; empties the queue, drops rsp_valid, seed becomes 1.
`default_nettype none

module lcg_uniform_int_range_unit #(
   parameter int QUEUE_DEPTH = lcgu_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  lcgu_pkg::lcgu_req_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output lcgu_pkg::lcgu_rsp_type rsp_word
);
   import lcgu_pkg::*;

   // front: order the bounds, size the span, screen seed loads
   lcgu_cmd_type front_cmd;
   // queue output toward the back end
   lcgu_cmd_type queue_cmd;
   logic         queue_valid;
   logic         back_ready;

   lcgu_front u_front (
      .req_word (req_word),
      .cmd_word (front_cmd)
   );

   // short queue: the front keeps taking words while the back end works
   lcgu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_word  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_word   (queue_cmd)
   );

   // back: advance the seed, map it into the interval, hold the result
   // in the output register until the consumer takes it
   lcgu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (back_ready),
      .cmd_word  (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
